/* sv/prgp_pkg.sv */
// ----------------------------------------------------------------------------
// prgp_pkg
// Shared types and constants of the pattern row gap packer.
// ----------------------------------------------------------------------------
package prgp_pkg;

    localparam int CHANNELS_DEF   = 8;
    localparam int FX_COLS        = 4;   // effect columns carried by one row word
    localparam int EFFECT_COLUMNS = 4;   // columns looked at; those past EFFECT_COLUMNS are absent
    localparam int VOICE_BYTES    = 5;
    localparam int NUM_STREAMS    = 4;

    localparam logic [7:0] NO_VOICE  = 8'd44;
    localparam logic [7:0] NO_EFFECT = 8'd255;
    localparam logic [7:0] MARKER    = 8'd255;
    localparam logic [7:0] GAP_MAX   = 8'd254;

    localparam logic [1:0] STREAM_NOTE  = 2'd0;
    localparam logic [1:0] STREAM_VOL   = 2'd1;
    localparam logic [1:0] STREAM_VOICE = 2'd2;
    localparam logic [1:0] STREAM_FX    = 2'd3;

    // Byte slots of one row, in output order
    localparam int SLOT_NOTE_GAP  = 0;
    localparam int SLOT_NOTE      = 1;
    localparam int SLOT_INST      = 2;
    localparam int SLOT_VOL_GAP   = 3;
    localparam int SLOT_VOL       = 4;
    localparam int SLOT_VOICE_GAP = 5;
    localparam int SLOT_VOICE0    = 6;
    localparam int SLOT_FX0       = SLOT_VOICE0 + VOICE_BYTES;
    localparam int SLOT_LONE0     = SLOT_FX0 + 3 * FX_COLS;
    localparam int NUM_SLOTS      = SLOT_LONE0 + NUM_STREAMS;
    localparam int SLOT_W         = $clog2(NUM_SLOTS);

    // Per-channel state word
    typedef struct packed {
        logic [NUM_STREAMS-1:0][7:0] gap;
        logic [NUM_STREAMS-1:0]      used;
        logic                        ovf;
    } t_entry;

    // One packed row handed to the byte emitter
    typedef struct packed {
        logic [NUM_SLOTS-1:0]        mask;
        logic [2:0]                  channel;
        logic                        ovf;
        logic [NUM_STREAMS-1:0][7:0] gap;
        logic [7:0]                  note;
        logic [7:0]                  inst;
        logic [7:0]                  vol;
        logic [VOICE_BYTES*8-1:0]    voice;
        logic [FX_COLS*8-1:0]        codes;
        logic [FX_COLS*8-1:0]        vals;
        logic [FX_COLS-1:0]          fx_first;
    } t_row;

endpackage

/* sv/prgp_state_mem.sv */
// ----------------------------------------------------------------------------
// prgp_state_mem
// Per-channel state memory: registered read, valid bits for the
// zero reset value, and forwarding of a write that lands with a read.
// ----------------------------------------------------------------------------
module prgp_state_mem #(
    parameter int CHANNELS = prgp_pkg::CHANNELS_DEF,
    localparam int ADDR_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_rd_en,
    input  logic [ADDR_W-1:0]    i_rd_addr,
    input  logic                 i_wr_en,
    input  logic [ADDR_W-1:0]    i_wr_addr,
    input  prgp_pkg::t_entry     i_wr_data,
    output prgp_pkg::t_entry     o_rd_data
);

    prgp_pkg::t_entry mem [CHANNELS];
    prgp_pkg::t_entry r_rd;
    prgp_pkg::t_entry r_fwd;
    logic             r_fwd_hit;
    logic             r_rd_vld;
    logic [CHANNELS-1:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd  <= mem[i_rd_addr];
            r_fwd <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_rd_vld  <= 1'b0;
            r_fwd_hit <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld  <= r_vld[i_rd_addr];
                r_fwd_hit <= i_wr_en && (i_wr_addr == i_rd_addr);
            end
        end
    end

    always_comb begin
        if (r_fwd_hit) begin
            o_rd_data = r_fwd;
        end else if (r_rd_vld) begin
            o_rd_data = r_rd;
        end else begin
            o_rd_data = '0;
        end
    end

endmodule

/* sv/prgp_byte_emitter.sv */
// ----------------------------------------------------------------------------
// prgp_byte_emitter
// Walks the enabled byte slots of one row, one word per cycle while the
// output is not stalled, into an output register.
// ----------------------------------------------------------------------------
module prgp_byte_emitter (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load,
    input  prgp_pkg::t_row i_row,
    output logic           o_can_load,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [1:0]     o_stream,
    output logic [2:0]     o_out_channel,
    output logic [7:0]     o_data_byte,
    output logic           o_gap_overflow,
    output logic           o_last
);

    localparam int NS = prgp_pkg::NUM_SLOTS;

    prgp_pkg::t_row                r_row;
    logic [NS-1:0]                 r_mask;
    logic [NS-1:0]                 n_mask;
    logic [NS-1:0]                 mask_rest;
    logic [prgp_pkg::SLOT_W-1:0]   first;
    logic                          out_free;
    logic                          emit;
    logic [NS-1:0][7:0]            slot_byte;
    logic [NS-1:0][1:0]            slot_stream;

    logic                          r_o_valid;
    logic [1:0]                    r_o_stream;
    logic [2:0]                    r_o_channel;
    logic [7:0]                    r_o_byte;
    logic                          r_o_ovf;
    logic                          r_o_last;

    always_comb begin
        first = '0;
        for (int j = NS - 1; j >= 0; j--) begin
            if (r_mask[j]) begin
                first = prgp_pkg::SLOT_W'(j);
            end
        end
    end

    always_comb begin
        slot_byte   = '0;
        slot_stream = '0;
        slot_byte[prgp_pkg::SLOT_NOTE_GAP]    = r_row.gap[prgp_pkg::STREAM_NOTE];
        slot_byte[prgp_pkg::SLOT_NOTE]        = r_row.note;
        slot_byte[prgp_pkg::SLOT_INST]        = r_row.inst;
        slot_byte[prgp_pkg::SLOT_VOL_GAP]     = r_row.gap[prgp_pkg::STREAM_VOL];
        slot_byte[prgp_pkg::SLOT_VOL]         = r_row.vol;
        slot_byte[prgp_pkg::SLOT_VOICE_GAP]   = r_row.gap[prgp_pkg::STREAM_VOICE];
        slot_stream[prgp_pkg::SLOT_NOTE_GAP]  = prgp_pkg::STREAM_NOTE;
        slot_stream[prgp_pkg::SLOT_NOTE]      = prgp_pkg::STREAM_NOTE;
        slot_stream[prgp_pkg::SLOT_INST]      = prgp_pkg::STREAM_NOTE;
        slot_stream[prgp_pkg::SLOT_VOL_GAP]   = prgp_pkg::STREAM_VOL;
        slot_stream[prgp_pkg::SLOT_VOL]       = prgp_pkg::STREAM_VOL;
        slot_stream[prgp_pkg::SLOT_VOICE_GAP] = prgp_pkg::STREAM_VOICE;
        for (int i = 0; i < prgp_pkg::VOICE_BYTES; i++) begin
            slot_byte[prgp_pkg::SLOT_VOICE0 + i]   = r_row.voice[8*i +: 8];
            slot_stream[prgp_pkg::SLOT_VOICE0 + i] = prgp_pkg::STREAM_VOICE;
        end
        for (int k = 0; k < prgp_pkg::FX_COLS; k++) begin
            // first present column carries the gap, later ones the marker
            slot_byte[prgp_pkg::SLOT_FX0 + 3*k]     = r_row.fx_first[k]
                ? r_row.gap[prgp_pkg::STREAM_FX] : prgp_pkg::MARKER;
            slot_byte[prgp_pkg::SLOT_FX0 + 3*k + 1] = r_row.codes[8*k +: 8];
            slot_byte[prgp_pkg::SLOT_FX0 + 3*k + 2] = r_row.vals[8*k +: 8];
            slot_stream[prgp_pkg::SLOT_FX0 + 3*k]     = prgp_pkg::STREAM_FX;
            slot_stream[prgp_pkg::SLOT_FX0 + 3*k + 1] = prgp_pkg::STREAM_FX;
            slot_stream[prgp_pkg::SLOT_FX0 + 3*k + 2] = prgp_pkg::STREAM_FX;
        end
        for (int s = 0; s < prgp_pkg::NUM_STREAMS; s++) begin
            slot_byte[prgp_pkg::SLOT_LONE0 + s]   = r_row.gap[s];
            slot_stream[prgp_pkg::SLOT_LONE0 + s] = 2'(s);
        end
    end

    assign out_free   = !r_o_valid || i_ready;
    assign emit       = (r_mask != '0) && out_free;
    assign mask_rest  = r_mask & ~(NS'(1) << first);
    assign o_can_load = emit ? (mask_rest == '0) : (r_mask == '0);

    always_comb begin
        n_mask = r_mask;
        if (i_load) begin
            n_mask = i_row.mask;
        end else if (emit) begin
            n_mask = mask_rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_mask <= n_mask;
            if (out_free) begin
                r_o_valid <= emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_row <= i_row;
        end
        if (emit) begin
            r_o_stream  <= slot_stream[first];
            r_o_channel <= r_row.channel;
            r_o_byte    <= slot_byte[first];
            r_o_ovf     <= r_row.ovf;
            r_o_last    <= (mask_rest == '0);
        end
    end

    assign o_valid        = r_o_valid;
    assign o_stream       = r_o_stream;
    assign o_out_channel  = r_o_channel;
    assign o_data_byte    = r_o_byte;
    assign o_gap_overflow = r_o_ovf;
    assign o_last         = r_o_last;

endmodule

/* sv/pattern_row_gap_packer_unit.sv */
// ----------------------------------------------------------------------------
// pattern_row_gap_packer_unit
// Packs channel pattern rows into note, volume, voice and effect gap streams.
// ----------------------------------------------------------------------------
// A row word is taken into the input register; its channel state is read
// from a registered memory, updated and written back as the row loads into
// the byte emitter, and the row then drains as one output word per cycle
// while the output is not stalled. A row makes up to 23 words; the byte
// emitter is the bottleneck. Rows for any channel may follow each other
// directly: a write-back to the channel being read is forwarded. Rows whose
// channel is at or above CHANNELS are taken and dropped.
module pattern_row_gap_packer_unit #(
    parameter int CHANNELS = prgp_pkg::CHANNELS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [2:0]           i_channel,
    input  logic signed [8:0]    i_note,
    input  logic signed [8:0]    i_instrument,
    input  logic signed [8:0]    i_volume,
    input  logic [39:0]          i_voice_bytes,
    input  logic [31:0]          i_effect_codes,
    input  logic [31:0]          i_effect_values,
    input  logic                 i_last_row,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [1:0]           o_stream,
    output logic [2:0]           o_out_channel,
    output logic [7:0]           o_data_byte,
    output logic                 o_gap_overflow,
    output logic                 o_last
);

    localparam int ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int NST    = prgp_pkg::NUM_STREAMS;

    logic                 accept;
    logic                 in_range;
    logic                 a_adv;
    logic                 can_load;

    logic                 r_a_valid;
    logic [2:0]           r_a_channel;
    logic signed [8:0]    r_a_note;
    logic signed [8:0]    r_a_inst;
    logic signed [8:0]    r_a_vol;
    logic [39:0]          r_a_voice;
    logic [31:0]          r_a_codes;
    logic [31:0]          r_a_vals;
    logic                 r_a_last;

    prgp_pkg::t_entry     ent;
    prgp_pkg::t_entry     wr_ent;
    prgp_pkg::t_row       row;

    logic [NST-1:0]       has_ev;
    logic [NST-1:0]       used_new;
    logic                 ovf_new;
    logic [prgp_pkg::FX_COLS-1:0] fx_present;
    logic [prgp_pkg::FX_COLS-1:0] fx_first;
    logic [NST-1:0][7:0]  g_emit;
    logic [NST-1:0][7:0]  g_next;
    logic                 seen_fx;

    assign in_range = (32'(i_channel) < CHANNELS);
    assign a_adv    = r_a_valid && can_load;
    assign o_ready  = !r_a_valid || can_load;
    assign accept   = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (accept) begin
            r_a_valid <= in_range;
        end else if (a_adv) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_channel <= i_channel;
            r_a_note    <= i_note;
            r_a_inst    <= i_instrument;
            r_a_vol     <= i_volume;
            r_a_voice   <= i_voice_bytes;
            r_a_codes   <= i_effect_codes;
            r_a_vals    <= i_effect_values;
            r_a_last    <= i_last_row;
        end
    end

    prgp_state_mem #(
        .CHANNELS (CHANNELS)
    ) u_state_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_addr (ADDR_W'(i_channel)),
        .i_wr_en   (a_adv),
        .i_wr_addr (ADDR_W'(r_a_channel)),
        .i_wr_data (wr_ent),
        .o_rd_data (ent)
    );

    // Row update: events, gap bump with saturation, write-back word, packed row
    always_comb begin
        has_ev[prgp_pkg::STREAM_NOTE]  = !r_a_note[8];
        has_ev[prgp_pkg::STREAM_VOL]   = !r_a_vol[8];
        has_ev[prgp_pkg::STREAM_VOICE] = 1'b0;
        for (int i = 0; i < prgp_pkg::VOICE_BYTES; i++) begin
            if (r_a_voice[8*i +: 8] != prgp_pkg::NO_VOICE) begin
                has_ev[prgp_pkg::STREAM_VOICE] = 1'b1;
            end
        end
        seen_fx = 1'b0;
        for (int k = 0; k < prgp_pkg::FX_COLS; k++) begin
            fx_present[k] = (k < prgp_pkg::EFFECT_COLUMNS)
                         && (r_a_codes[8*k +: 8] != prgp_pkg::NO_EFFECT);
            fx_first[k]   = fx_present[k] && !seen_fx;
            seen_fx       = seen_fx || fx_present[k];
        end
        has_ev[prgp_pkg::STREAM_FX] = seen_fx;

        ovf_new = ent.ovf;
        for (int s = 0; s < NST; s++) begin
            if (has_ev[s]) begin
                g_emit[s] = ent.gap[s];
                g_next[s] = '0;
            end else if (ent.gap[s] >= prgp_pkg::GAP_MAX) begin
                g_emit[s] = prgp_pkg::GAP_MAX;
                g_next[s] = prgp_pkg::GAP_MAX;
                ovf_new   = 1'b1;
            end else begin
                g_emit[s] = ent.gap[s] + 8'd1;
                g_next[s] = ent.gap[s] + 8'd1;
            end
        end
        used_new = ent.used | has_ev;

        if (r_a_last) begin
            wr_ent = '0;
        end else begin
            wr_ent.gap  = g_next;
            wr_ent.used = used_new;
            wr_ent.ovf  = ovf_new;
        end

        row.mask = '0;
        row.mask[prgp_pkg::SLOT_NOTE_GAP]  = has_ev[prgp_pkg::STREAM_NOTE];
        row.mask[prgp_pkg::SLOT_NOTE]      = has_ev[prgp_pkg::STREAM_NOTE];
        row.mask[prgp_pkg::SLOT_INST]      = has_ev[prgp_pkg::STREAM_NOTE];
        row.mask[prgp_pkg::SLOT_VOL_GAP]   = has_ev[prgp_pkg::STREAM_VOL];
        row.mask[prgp_pkg::SLOT_VOL]       = has_ev[prgp_pkg::STREAM_VOL];
        row.mask[prgp_pkg::SLOT_VOICE_GAP] = has_ev[prgp_pkg::STREAM_VOICE];
        for (int i = 0; i < prgp_pkg::VOICE_BYTES; i++) begin
            row.mask[prgp_pkg::SLOT_VOICE0 + i] = has_ev[prgp_pkg::STREAM_VOICE];
        end
        for (int k = 0; k < prgp_pkg::FX_COLS; k++) begin
            row.mask[prgp_pkg::SLOT_FX0 + 3*k]     = fx_present[k];
            row.mask[prgp_pkg::SLOT_FX0 + 3*k + 1] = fx_present[k];
            row.mask[prgp_pkg::SLOT_FX0 + 3*k + 2] = fx_present[k];
        end
        // streams silent for the whole frame send their gap on the last row
        for (int s = 0; s < NST; s++) begin
            row.mask[prgp_pkg::SLOT_LONE0 + s] = r_a_last && !used_new[s];
        end
        row.channel  = r_a_channel;
        row.ovf      = ovf_new;
        row.gap      = g_emit;
        row.note     = r_a_note[7:0];
        row.inst     = r_a_inst[7:0];
        row.vol      = r_a_vol[7:0];
        row.voice    = r_a_voice;
        row.codes    = r_a_codes;
        row.vals     = r_a_vals;
        row.fx_first = fx_first;
    end

    prgp_byte_emitter u_emitter (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (a_adv),
        .i_row          (row),
        .o_can_load     (can_load),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_stream       (o_stream),
        .o_out_channel  (o_out_channel),
        .o_data_byte    (o_data_byte),
        .o_gap_overflow (o_gap_overflow),
        .o_last         (o_last)
    );

endmodule

/* sv/prgp_checker.sv */
// ----------------------------------------------------------------------------
// prgp_checker
// Port-level checks of the gap packer, bound to the top level.
// ----------------------------------------------------------------------------
module prgp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_ready,
    input logic [2:0] o_out_channel,
    input logic       o_gap_overflow,
    input logic       o_last
);

    // stalled word stays offered
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("output word dropped while stalled");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // words of one row follow without a bubble, on the same channel
    a_row_chan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last |=>
            o_valid && (o_out_channel == $past(o_out_channel)))
        else $error("row words broken up or channel changed within a row");

    a_row_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last |=> o_gap_overflow == $past(o_gap_overflow))
        else $error("overflow flag changed within a row");

endmodule

bind pattern_row_gap_packer_unit prgp_checker u_prgp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_out_channel  (o_out_channel),
    .o_gap_overflow (o_gap_overflow),
    .o_last         (o_last)
);
